[src/sha1_byte_stream_hasher_assert.svh]
// Assertion macros for the SHA-1 byte stream hasher.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHA1BSH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 hasher: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SHA1BSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 hasher: next-cycle check failed");

`endif

[src/sha1bsh_pkg.sv]
// Shared types, constants and helper functions of the SHA-1 byte stream hasher.
// No dependencies.
package sha1bsh_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int SCHED_WORDS = BLOCK_BYTES / 4;
  localparam int DIGEST_WORDS = 5;

  typedef logic [31:0] word_t;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Byte positions within a block: last byte, and last byte before the length field.
  localparam logic [5:0] POS_LAST     = 6'd63;
  localparam logic [5:0] POS_PAD_LAST = 6'd55;

  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam word_t K_0 = 32'h5a827999;
  localparam word_t K_1 = 32'h6ed9eba1;
  localparam word_t K_2 = 32'h8f1bbcdc;
  localparam word_t K_3 = 32'hca62c1d6;

  localparam word_t H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_BYTE,
    CELL_WORD
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       add;
    logic       clear;
    logic [6:0] round;
  } round_ctl_t;

  function automatic word_t rotl1(word_t v);
    return {v[30:0], v[31]};
  endfunction

  function automatic word_t rotl5(word_t v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic word_t rotl30(word_t v);
    return {v[1:0], v[31:2]};
  endfunction

endpackage

[src/sha1bsh_cell.sv]
// One 32-bit cell of the block buffer / message schedule chain.
// Shifts in a byte or a whole word from its neighbor. Uses sha1bsh_pkg.
module sha1bsh_cell (
  input  logic                clk,
  input  sha1bsh_pkg::cell_op_t op,
  input  logic [7:0]          byte_in,
  input  sha1bsh_pkg::word_t  word_in,
  output sha1bsh_pkg::word_t  word_q
);
  import sha1bsh_pkg::*;

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    unique case (op)
      CELL_BYTE: word_nxt = {word_r[23:0], byte_in};
      CELL_WORD: word_nxt = word_in;
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

[src/sha1bsh_round.sv]
// SHA-1 round unit: working variables a..e and the chaining digest.
// One round per cycle under control of the sequencer. Uses sha1bsh_pkg.
module sha1bsh_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1bsh_pkg::round_ctl_t ctl,
  input  sha1bsh_pkg::word_t     w_in,
  output sha1bsh_pkg::word_t     digest [sha1bsh_pkg::DIGEST_WORDS]
);
  import sha1bsh_pkg::*;

  word_t a_r, b_r, c_r, d_r, e_r;
  word_t h_r [DIGEST_WORDS];
  word_t f_val;
  word_t k_val;
  word_t t_val;

  always_comb begin
    priority if (ctl.round < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_0;
    end else if (ctl.round < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_1;
    end else if (ctl.round < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_3;
    end
    t_val = rotl5(a_r) + f_val + e_r + k_val + w_in;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (ctl.step) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= rotl30(b_r);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      h_r <= H_INIT;
    end else if (ctl.add) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  assign digest = h_r;

endmodule

[src/sha1_byte_stream_hasher.sv]
// Top level of the SHA-1 byte stream hasher: sequencer, byte counter, output buffer.
// Uses sha1bsh_pkg, sha1bsh_cell, sha1bsh_round and the assertion macro header.
//
//   channel | direction | ports                                          | word
//   in      | input     | in_valid, in_stall, in_cmd, in_data_byte        | one byte or finish
//   out     | output    | out_valid, out_stall, out_digest_word,          | one digest word
//           |           | out_word_index, out_last, out_error             |
//
// A data byte is taken while the sequencer is idle; the byte that fills a block starts
// the load, 80 rounds and digest add, set by the single round unit and the 16-cell chain.
// A finish is followed by the padding bytes, eight length bytes, one or two compressions
// and the move of the digest into the output buffer.
// Reset is synchronous; it restores the initial digest and clears all control state.
// Digest words wait in their own buffer, so byte input resumes while they drain;
// a finish is held off until the previous digest has been taken.
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last,
  output logic        out_error
);
  import sha1bsh_pkg::*;

  state_t      state_r, state_nxt;
  logic [63:0] bit_cnt_r, bit_cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [5:0]  pad_cnt_r, pad_cnt_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic [6:0]  round_cnt_r, round_cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        pad_r, pad_nxt;

  word_t       obuf_r [DIGEST_WORDS];
  logic [2:0]  out_idx_r;
  logic        out_valid_r;
  logic        out_err_r;

  cell_op_t    cell_op;
  logic [7:0]  shift_byte;
  word_t       cell_q [SCHED_WORDS];
  word_t       sched_new;
  round_ctl_t  rctl;
  word_t       digest [DIGEST_WORDS];
  logic        dump;
  logic        in_acc;
  logic        out_acc;
  logic [5:0]  fill;
  logic        count_full;
  logic        fin_acc;
  logic        pad_phase;

  assign fill       = bit_cnt_r[8:3];
  assign count_full = &bit_cnt_r[63:3];
  assign in_stall   = (state_r != S_IDLE) || ((in_cmd == CMD_FINISH) && out_valid_r);
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid_r && !out_stall;

  // Schedule word sixteen rounds ahead of the one at the head of the chain.
  assign sched_new = rotl1(cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0]);

  for (genvar i = 0; i < SCHED_WORDS; i++) begin : g_cell
    logic [7:0] byte_link;
    word_t      word_link;
    if (i == SCHED_WORDS - 1) begin : g_tail
      assign byte_link = shift_byte;
      assign word_link = sched_new;
    end else begin : g_body
      assign byte_link = cell_q[i + 1][31:24];
      assign word_link = cell_q[i + 1];
    end
    sha1bsh_cell u_cell (
      .clk     (clk),
      .op      (cell_op),
      .byte_in (byte_link),
      .word_in (word_link),
      .word_q  (cell_q[i])
    );
  end

  sha1bsh_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rctl),
    .w_in   (cell_q[0]),
    .digest (digest)
  );

  // Where padding goes after writing the byte at position pos.
  function automatic state_t pad_next(logic [5:0] pos);
    state_t s;
    if (pos == POS_LAST) begin
      s = S_LOAD;
    end else if (pos == POS_PAD_LAST) begin
      s = S_LEN;
    end else begin
      s = S_PAD;
    end
    return s;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    ovf_nxt       = ovf_r;
    pad_cnt_nxt   = pad_cnt_r;
    len_idx_nxt   = len_idx_r;
    round_cnt_nxt = round_cnt_r;
    fin_nxt       = fin_r;
    pad_nxt       = pad_r;
    cell_op       = CELL_HOLD;
    shift_byte    = '0;
    rctl          = '0;
    rctl.round    = round_cnt_r;
    dump          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_DATA) begin
            // Bytes that would carry the counter past its top are dropped.
            if (count_full) begin
              ovf_nxt = 1'b1;
            end else begin
              cell_op     = CELL_BYTE;
              shift_byte  = in_data_byte;
              bit_cnt_nxt = bit_cnt_r + 64'd8;
              if (fill == POS_LAST) begin
                state_nxt = S_LOAD;
              end
            end
          end else begin
            cell_op     = CELL_BYTE;
            shift_byte  = PAD_BYTE;
            pad_nxt     = 1'b1;
            pad_cnt_nxt = fill + 6'd1;
            state_nxt   = pad_next(fill);
          end
        end
      end
      S_PAD: begin
        cell_op     = CELL_BYTE;
        pad_cnt_nxt = pad_cnt_r + 6'd1;
        state_nxt   = pad_next(pad_cnt_r);
      end
      S_LEN: begin
        cell_op     = CELL_BYTE;
        shift_byte  = bit_cnt_r[{~len_idx_r, 3'b000} +: 8];
        len_idx_nxt = len_idx_r + 3'd1;
        if (len_idx_r == 3'd7) begin
          fin_nxt   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        rctl.load     = 1'b1;
        round_cnt_nxt = '0;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        rctl.step     = 1'b1;
        cell_op       = CELL_WORD;
        round_cnt_nxt = round_cnt_r + 7'd1;
        if (round_cnt_r == ROUND_LAST) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        rctl.add = 1'b1;
        priority if (fin_r) begin
          state_nxt = S_DONE;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        dump        = 1'b1;
        rctl.clear  = 1'b1;
        bit_cnt_nxt = '0;
        ovf_nxt     = 1'b0;
        fin_nxt     = 1'b0;
        pad_nxt     = 1'b0;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      pad_cnt_r   <= '0;
      len_idx_r   <= '0;
      round_cnt_r <= '0;
      fin_r       <= 1'b0;
      pad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      ovf_r       <= ovf_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
      len_idx_r   <= len_idx_nxt;
      round_cnt_r <= round_cnt_nxt;
      fin_r       <= fin_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else if (dump) begin
      out_valid_r <= 1'b1;
      out_idx_r   <= '0;
    end else if (out_acc) begin
      out_idx_r <= out_idx_r + 3'd1;
      if (out_idx_r == 3'(DIGEST_WORDS - 1)) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dump) begin
      obuf_r    <= digest;
      out_err_r <= ovf_r;
    end else if (out_acc) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        obuf_r[i] <= obuf_r[i + 1];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = obuf_r[0];
  assign out_word_index  = out_idx_r;
  assign out_last        = (out_idx_r == 3'(DIGEST_WORDS - 1));
  assign out_error       = out_err_r;

  assign fin_acc   = in_acc && (in_cmd == CMD_FINISH);
  assign pad_phase = (state_r == S_PAD) || (state_r == S_LEN) || (state_r == S_LOAD);

`include "sha1_byte_stream_hasher_assert.svh"

  `SHA1BSH_ASSERT_NOW(a_round_range, state_r == S_ROUND, round_cnt_r <= ROUND_LAST)
  `SHA1BSH_ASSERT_NEXT(a_finish_busy, fin_acc, pad_phase)
  `SHA1BSH_ASSERT_NOW(a_dump_free, state_r == S_DONE, !out_valid_r)
  `SHA1BSH_ASSERT_NOW(a_out_index, out_valid_r, out_idx_r <= 3'(DIGEST_WORDS - 1))

endmodule
